### rtl/cps_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and saturation helpers for the clamped polynomial block.
// No dependencies; used by cps_horner_step and clamped_polynomial_with_slope.
package cps_pkg;

  localparam int DATA_W  = 32;  // Q16.16 operands, coefficients and results
  localparam int ACC_W   = 48;  // Q32.16 accumulators
  localparam int FRAC_W  = 16;
  localparam int NCOEF   = 5;   // coefficient registers present in the map
  localparam int SLOPE_W = 35;  // coefficient times a power index of at most four
  localparam int WIDE_W  = 65;  // rounded product before saturation

  localparam logic signed [ACC_W-1:0]  ACC_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0]  ACC_MIN = 48'sh8000_0000_0000;
  localparam logic signed [DATA_W-1:0] OUT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] OUT_MIN = 32'sh8000_0000;

  // Configuration register map.
  typedef enum logic [2:0] {
    REG_COEF0     = 3'd0,
    REG_COEF1     = 3'd1,
    REG_COEF2     = 3'd2,
    REG_COEF3     = 3'd3,
    REG_COEF4     = 3'd4,
    REG_MIN_LIMIT = 3'd5,
    REG_MAX_LIMIT = 3'd6,
    REG_ABS_MODE  = 3'd7
  } cfg_reg_t;

  // One item as it moves down the Horner chain.
  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [ACC_W-1:0]  f0;
    logic signed [ACC_W-1:0]  f1;
  } acc_t;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [WIDE_W-1:0] v);
    logic signed [ACC_W-1:0] res;
    if (v > WIDE_W'(ACC_MAX)) begin
      res = ACC_MAX;
    end else if (v < WIDE_W'(ACC_MIN)) begin
      res = ACC_MIN;
    end else begin
      res = v[ACC_W-1:0];
    end
    return res;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
    logic signed [DATA_W-1:0] res;
    if (v > ACC_W'(OUT_MAX)) begin
      res = OUT_MAX;
    end else if (v < ACC_W'(OUT_MIN)) begin
      res = OUT_MIN;
    end else begin
      res = v[DATA_W-1:0];
    end
    return res;
  endfunction

endpackage

### rtl/cps_horner_step.sv
`timescale 1ns / 1ps
// One Horner step for value and slope: split multiply, round and saturate, add coefficient.
// Three register stages with a valid/ready chain. Depends on cps_pkg.
module cps_horner_step (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  cps_pkg::acc_t                          in_data,
  input  logic signed [cps_pkg::DATA_W-1:0]      coef_add,
  input  logic signed [cps_pkg::SLOPE_W-1:0]     slope_term,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output cps_pkg::acc_t                          out_data
);
  import cps_pkg::*;

  localparam int HI_W  = ACC_W - FRAC_W;       // 32
  localparam int LO_W  = FRAC_W + 1 + DATA_W;  // 49, unsigned low part times x
  localparam int PH_W  = HI_W + DATA_W;        // 64
  localparam int SUM_W = ACC_W + 1;

  // Multiply stage: the 48-bit accumulator is split into a signed high word
  // and an unsigned low half so each product stays within 32 by 32 bits.
  logic                      m_valid;
  logic signed [DATA_W-1:0]  m_x;
  logic signed [PH_W-1:0]    m_hi0;
  logic signed [LO_W-1:0]    m_lo0;
  logic signed [PH_W-1:0]    m_hi1;
  logic signed [LO_W-1:0]    m_lo1;

  // Round stage.
  logic                      r_valid;
  logic signed [DATA_W-1:0]  r_x;
  logic signed [ACC_W-1:0]   r_f0;
  logic signed [ACC_W-1:0]   r_f1;

  // Coefficient stage.
  logic                      c_valid;
  acc_t                      c_data;

  logic m_ready, r_ready, c_ready;

  logic signed [HI_W-1:0]    hi0_w, hi1_w;
  logic signed [FRAC_W:0]    lo0_w, lo1_w;
  logic signed [PH_W-1:0]    hi0_x, hi1_x;
  logic signed [LO_W-1:0]    lo0_x, lo1_x;
  logic signed [LO_W-1:0]    rnd0, rnd1;
  logic signed [WIDE_W-1:0]  wide0, wide1;
  logic signed [SUM_W-1:0]   sum0, sum1;

  assign c_ready  = !c_valid || out_ready;
  assign r_ready  = !r_valid || c_ready;
  assign m_ready  = !m_valid || r_ready;
  assign in_ready = m_ready;

  assign hi0_w = in_data.f0[ACC_W-1:FRAC_W];
  assign hi1_w = in_data.f1[ACC_W-1:FRAC_W];
  assign lo0_w = $signed({1'b0, in_data.f0[FRAC_W-1:0]});
  assign lo1_w = $signed({1'b0, in_data.f1[FRAC_W-1:0]});
  assign hi0_x = hi0_w * in_data.x;
  assign hi1_x = hi1_w * in_data.x;
  assign lo0_x = lo0_w * in_data.x;
  assign lo1_x = lo1_w * in_data.x;

  // Round half up on the low partial product, then add the high one.
  assign rnd0  = m_lo0 + LO_W'(32768);
  assign rnd1  = m_lo1 + LO_W'(32768);
  assign wide0 = WIDE_W'(m_hi0) + WIDE_W'($signed(rnd0[LO_W-1:FRAC_W]));
  assign wide1 = WIDE_W'(m_hi1) + WIDE_W'($signed(rnd1[LO_W-1:FRAC_W]));

  assign sum0 = SUM_W'(r_f0) + SUM_W'(coef_add);
  assign sum1 = SUM_W'(r_f1) + SUM_W'(slope_term);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      r_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (m_ready) m_valid <= in_valid;
      if (r_ready) r_valid <= m_valid;
      if (c_ready) c_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_ready) begin
      m_x   <= in_data.x;
      m_hi0 <= hi0_x;
      m_lo0 <= lo0_x;
      m_hi1 <= hi1_x;
      m_lo1 <= lo1_x;
    end
    if (r_ready) begin
      r_x  <= m_x;
      r_f0 <= sat_acc(wide0);
      r_f1 <= sat_acc(wide1);
    end
    if (c_ready) begin
      c_data.x  <= r_x;
      c_data.f0 <= sat_acc(WIDE_W'(sum0));
      c_data.f1 <= sat_acc(WIDE_W'(sum1));
    end
  end

  assign out_valid = c_valid;
  assign out_data  = c_data;

endmodule

### rtl/clamped_polynomial_with_slope.sv
`timescale 1ns / 1ps
// Top level: configuration registers, Horner chain of DEGREE steps, absolute fold and clamp.
// Depends on cps_pkg and cps_horner_step.

// Evaluates coef0 + coef1*x + ... + coefDEGREE*x^DEGREE and its derivative for
// one signed Q16.16 operand per beat, by Horner's rule in 48-bit Q32.16
// accumulators that round half up and saturate at every step. In absolute
// mode a negative value is negated together with its slope; the value is then
// clamped to [min_limit, max_limit] (upper test first), a clamp forces the
// slope to zero, and both results saturate to 32 bits. The block takes one
// operand every cycle unless a stalled result channel holds it off. Each
// Horner step is a three-stage unit (split multiply, round and saturate,
// coefficient add), followed by the absolute-fold stage and the output
// register. Stalls move back stage by stage, so empty stages keep filling
// while a result waits. Configuration writes are always accepted (cfg_ready
// is tied high) and take effect at once; write them only while no beat is in flight.
module clamped_polynomial_with_slope #(
  parameter int DEGREE = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  // Operand channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [cps_pkg::DATA_W-1:0] x_in,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [cps_pkg::DATA_W-1:0] x_out,
  output logic signed [cps_pkg::DATA_W-1:0] value,
  output logic signed [cps_pkg::DATA_W-1:0] slope,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  cps_pkg::cfg_reg_t                 cfg_index,
  input  logic [cps_pkg::DATA_W-1:0]        cfg_data
);
  import cps_pkg::*;

  // Configuration registers.
  logic signed [DATA_W-1:0] coef [NCOEF];
  logic signed [DATA_W-1:0] min_limit;
  logic signed [DATA_W-1:0] max_limit;
  logic                     abs_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCOEF; i++) begin
        coef[i] <= '0;
      end
      min_limit <= OUT_MIN;
      max_limit <= OUT_MAX;
      abs_mode  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COEF0:     coef[0]   <= $signed(cfg_data);
        REG_COEF1:     coef[1]   <= $signed(cfg_data);
        REG_COEF2:     coef[2]   <= $signed(cfg_data);
        REG_COEF3:     coef[3]   <= $signed(cfg_data);
        REG_COEF4:     coef[4]   <= $signed(cfg_data);
        REG_MIN_LIMIT: min_limit <= $signed(cfg_data);
        REG_MAX_LIMIT: max_limit <= $signed(cfg_data);
        REG_ABS_MODE:  abs_mode  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Horner chain. Link k carries the item into step k; the first accumulator
  // is simply the top coefficient, and the slope starts at zero.
  logic [DEGREE:0] link_valid;
  logic [DEGREE:0] link_ready;
  acc_t            link_data [DEGREE+1];

  assign link_valid[0]   = in_valid;
  assign link_data[0].x  = x_in;
  assign link_data[0].f0 = ACC_W'(coef[DEGREE]);
  assign link_data[0].f1 = '0;
  assign in_stall        = !link_ready[0];

  for (genvar k = 0; k < DEGREE; k++) begin : g_step
    // Step k works on power index DEGREE-k: the value picks up the next lower
    // coefficient, the slope picks up this coefficient times its index.
    localparam int PIDX = DEGREE - k;
    logic signed [SLOPE_W-1:0] slope_term;

    assign slope_term = SLOPE_W'(coef[PIDX]) * SLOPE_W'(PIDX);

    cps_horner_step u_step (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (link_valid[k]),
      .in_ready   (link_ready[k]),
      .in_data    (link_data[k]),
      .coef_add   (coef[PIDX-1]),
      .slope_term (slope_term),
      .out_valid  (link_valid[k+1]),
      .out_ready  (link_ready[k+1]),
      .out_data   (link_data[k+1])
    );
  end

  // Absolute-fold stage. Negation saturates at the most negative accumulator.
  logic                     fold_valid;
  logic signed [DATA_W-1:0] fold_x;
  logic signed [ACC_W-1:0]  fold_f0;
  logic signed [ACC_W-1:0]  fold_f1;
  logic                     fold_ready;
  logic                     out_ready;
  logic                     negate;
  logic signed [ACC_W-1:0]  neg_f0;
  logic signed [ACC_W-1:0]  neg_f1;

  assign out_ready            = !out_valid || !out_stall;
  assign fold_ready           = !fold_valid || out_ready;
  assign link_ready[DEGREE]   = fold_ready;

  assign negate = abs_mode && link_data[DEGREE].f0[ACC_W-1];
  assign neg_f0 = (link_data[DEGREE].f0 == ACC_MIN) ? ACC_MAX : -link_data[DEGREE].f0;
  assign neg_f1 = (link_data[DEGREE].f1 == ACC_MIN) ? ACC_MAX : -link_data[DEGREE].f1;

  // Clamp and output saturation. A value that is not clamped lies between two
  // 32-bit limits, so its low word is already the saturated result.
  logic signed [DATA_W-1:0] value_next;
  logic signed [DATA_W-1:0] slope_next;

  always_comb begin
    if (fold_f0 > ACC_W'(max_limit)) begin
      value_next = max_limit;
      slope_next = '0;
    end else if (fold_f0 < ACC_W'(min_limit)) begin
      value_next = min_limit;
      slope_next = '0;
    end else begin
      value_next = fold_f0[DATA_W-1:0];
      slope_next = sat_out(fold_f1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (fold_ready) fold_valid <= link_valid[DEGREE];
      if (out_ready)  out_valid  <= fold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fold_ready) begin
      fold_x  <= link_data[DEGREE].x;
      fold_f0 <= negate ? neg_f0 : link_data[DEGREE].f0;
      fold_f1 <= negate ? neg_f1 : link_data[DEGREE].f1;
    end
    if (out_ready) begin
      x_out <= fold_x;
      value <= value_next;
      slope <= slope_next;
    end
  end

`ifndef ASSERT_OFF
  // Reset empties the whole pipeline, so no beat can be offered right after it.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered in the cycle after reset");

  // The operand side may only be held off by a result that is waiting to be taken.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("operand stalled while the result channel is free");
`endif

endmodule

### test/clamped_polynomial_with_slope_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for clamped_polynomial_with_slope: directed and random operands
// under several register settings and handshake pressure patterns.
// Depends on cps_pkg and the block's RTL only.
module clamped_polynomial_with_slope_test;
  import cps_pkg::*;

  localparam int DEGREE = 4;
  // Three stages per Horner step plus the absolute-fold stage and the output register.
  localparam int PIPE_LATENCY = 3 * DEGREE + 2;
  // A clean run ends before this limit even with heavy stalls, so the
  // limit is only reached when the block hangs.
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_SETTING = 50;
  localparam int SETTINGS_PER_PHASE = 8;

  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sd65536;

  // Wide signed type for the predictor: an 80-bit product of a 48-bit accumulator
  // and a 32-bit operand fits with room to spare.
  typedef logic signed [95:0] wide_t;

  localparam wide_t ACC_HI = (wide_t'(1) <<< 47) - 1;
  localparam wide_t ACC_LO = -(wide_t'(1) <<< 47);
  localparam wide_t OUT_HI = (wide_t'(1) <<< 31) - 1;
  localparam wide_t OUT_LO = -(wide_t'(1) <<< 31);

  typedef struct {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] slope;
  } poly_result_t;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [DATA_W-1:0]   x_in;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [DATA_W-1:0]   x_out;
  logic signed [DATA_W-1:0]   value;
  logic signed [DATA_W-1:0]   slope;
  logic                       cfg_valid;
  logic                       cfg_ready;
  cfg_reg_t                   cfg_index;
  logic [DATA_W-1:0]          cfg_data;

  // Mirror of the configuration registers, updated when a write is accepted.
  wide_t poly_coef [NCOEF];
  wide_t lo_clamp;
  wide_t hi_clamp;
  logic  abs_on;

  // Results still owed by the block, oldest first.
  poly_result_t pending_results[$];

  int error_count = 0;
  int cycle_count = 0;
  int send_gap_pct = 0;
  int stall_pct = 0;

  clamped_polynomial_with_slope #(
    .DEGREE(DEGREE)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .x_in      (x_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .x_out     (x_out),
    .value     (value),
    .slope     (slope),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The cycle counter is the run's watchdog: a block that stops producing beats
  // ends the run here with the failure message.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("clamped_polynomial_with_slope_test: done, errors");
      $finish;
    end
  end

  // The receiver decides its stall for the coming edge at every falling edge.
  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < stall_pct);
  end

  function automatic wide_t clip(input wide_t v, input wide_t lo, input wide_t hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // One Horner multiply: exact product, drop 16 fraction bits rounding half up,
  // then saturate to the accumulator range.
  function automatic wide_t horner_mul(input wide_t acc, input wide_t x);
    wide_t prod;
    prod = acc * x + 32768;
    return clip(prod >>> FRAC_W, ACC_LO, ACC_HI);
  endfunction

  // Value and slope of the configured polynomial at one operand, after the
  // absolute fold, the clamp and the final saturation.
  function automatic poly_result_t evaluate_poly(input logic signed [DATA_W-1:0] x_op);
    wide_t        x;
    wide_t        f0;
    wide_t        f1;
    poly_result_t res;
    x  = wide_t'(x_op);
    f0 = 0;
    f1 = 0;
    for (int i = DEGREE; i > 0; i--) begin
      f0 = clip(f0 + poly_coef[i], ACC_LO, ACC_HI);
      f0 = horner_mul(f0, x);
      f1 = horner_mul(f1, x);
      f1 = clip(f1 + poly_coef[i] * i, ACC_LO, ACC_HI);
    end
    f0 = clip(f0 + poly_coef[0], ACC_LO, ACC_HI);
    // Negating the most negative accumulator saturates to the most positive one.
    if (abs_on && f0 < 0) begin
      f0 = clip(-f0, ACC_LO, ACC_HI);
      f1 = clip(-f1, ACC_LO, ACC_HI);
    end
    // The upper test comes first, which decides the outcome for inverted limits.
    if (f0 > hi_clamp) begin
      f0 = hi_clamp;
      f1 = 0;
    end else if (f0 < lo_clamp) begin
      f0 = lo_clamp;
      f1 = 0;
    end
    f0 = clip(f0, OUT_LO, OUT_HI);
    f1 = clip(f1, OUT_LO, OUT_HI);
    res.x     = x_op;
    res.value = f0[DATA_W-1:0];
    res.slope = f1[DATA_W-1:0];
    return res;
  endfunction

  // Every mismatch prints one line and is counted.
  task automatic report_mismatch(input string msg);
    $display("clamped_polynomial_with_slope_test: mismatch at cycle %0d: %s",
             cycle_count, msg);
    error_count++;
  endtask

  // Result checker: every beat on the result channel is compared field by field
  // with the oldest pending expectation.
  always @(posedge clk) begin
    poly_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat with none pending, x_out %h", x_out));
      end else begin
        want = pending_results.pop_front();
        if (x_out !== want.x) begin
          report_mismatch($sformatf("x_out expected %h, got %h", want.x, x_out));
        end
        if (value !== want.value) begin
          report_mismatch($sformatf("value for x %h expected %h, got %h",
                                    want.x, want.value, value));
        end
        if (slope !== want.slope) begin
          report_mismatch($sformatf("slope for x %h expected %h, got %h",
                                    want.x, want.slope, slope));
        end
      end
    end
  end

  // Sends one operand. The sender may idle first; valid stays high after the
  // beat so that back-to-back operands never see it drop and rise in one step.
  task automatic send_operand(input logic signed [DATA_W-1:0] x);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    x_in     = x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.insert(pending_results.size(), evaluate_poly(x));
    @(negedge clk);
  endtask

  // Waits until the block has delivered everything it owes and the pipeline has
  // had time to empty, leaving the testbench at a falling edge.
  task automatic drain_pipeline();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
    @(negedge clk);
  endtask

  // Valid stays high across consecutive writes; load_config lowers it at the end.
  task automatic write_reg(input cfg_reg_t idx, input logic [DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MIN_LIMIT: lo_clamp = wide_t'($signed(data));
      REG_MAX_LIMIT: hi_clamp = wide_t'($signed(data));
      REG_ABS_MODE:  abs_on = data[0];
      default:       poly_coef[int'(idx)] = wide_t'($signed(data));
    endcase
    @(negedge clk);
  endtask

  // Rewrites every register once the block is idle.
  task automatic load_config(input logic [DATA_W-1:0] c0, input logic [DATA_W-1:0] c1,
                             input logic [DATA_W-1:0] c2, input logic [DATA_W-1:0] c3,
                             input logic [DATA_W-1:0] c4, input logic [DATA_W-1:0] lo,
                             input logic [DATA_W-1:0] hi, input logic [DATA_W-1:0] abs_data);
    drain_pipeline();
    write_reg(REG_COEF0, c0);
    write_reg(REG_COEF1, c1);
    write_reg(REG_COEF2, c2);
    write_reg(REG_COEF3, c3);
    write_reg(REG_COEF4, c4);
    write_reg(REG_MIN_LIMIT, lo);
    write_reg(REG_MAX_LIMIT, hi);
    write_reg(REG_ABS_MODE, abs_data);
    cfg_valid = 1'b0;
  endtask

  // Uniform signed value in [-span, span], in raw Q16.16 units.
  function automatic logic [DATA_W-1:0] random_around_zero(input int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // Picks an extreme or near-extreme value; these drive the saturation paths.
  function automatic logic [DATA_W-1:0] random_extreme();
    logic [DATA_W-1:0] pick;
    case ($urandom_range(6))
      0:       pick = OUT_MAX;
      1:       pick = OUT_MIN;
      2:       pick = 0;
      3:       pick = 1;
      4:       pick = -1;
      5:       pick = Q_ONE;
      default: pick = -Q_ONE;
    endcase
    return pick;
  endfunction

  // Coefficients are mostly modest so that many results stay inside the clamp,
  // with full-range and extreme values mixed in.
  function automatic logic [DATA_W-1:0] random_coef();
    logic [DATA_W-1:0] pick;
    case ($urandom_range(4))
      0:       pick = $urandom;
      1:       pick = random_extreme();
      2:       pick = random_around_zero(64 << FRAC_W);
      default: pick = random_around_zero(2 << FRAC_W);
    endcase
    return pick;
  endfunction

  function automatic logic signed [DATA_W-1:0] random_operand();
    logic [DATA_W-1:0] pick;
    case ($urandom_range(4))
      0:       pick = $urandom;
      1:       pick = random_extreme();
      2:       pick = random_around_zero(256 << FRAC_W);
      default: pick = random_around_zero(4 << FRAC_W);
    endcase
    return $signed(pick);
  endfunction

  // A fresh random setting of all registers. Limits are sometimes the full
  // range, sometimes narrow, and sometimes inverted; abs_mode gets random high
  // bits, which the block must ignore.
  task automatic randomize_config();
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] swap;
    case ($urandom_range(3))
      0: begin
        lo = OUT_MIN;
        hi = OUT_MAX;
      end
      1: begin
        lo = random_around_zero(16 << FRAC_W);
        hi = random_around_zero(16 << FRAC_W);
      end
      2: begin
        lo = $urandom;
        hi = $urandom;
      end
      default: begin
        lo = random_around_zero(64 << FRAC_W);
        hi = random_around_zero(64 << FRAC_W);
        if ($signed(lo) > $signed(hi)) begin
          swap = lo;
          lo   = hi;
          hi   = swap;
        end
      end
    endcase
    load_config(random_coef(), random_coef(), random_coef(), random_coef(), random_coef(),
                lo, hi, $urandom);
  endtask

  // Straight after reset every coefficient is zero, so each result is zero with
  // the operand echoed, whatever the operand.
  task automatic test_reset_state();
    send_operand(OUT_MAX);
    send_operand(OUT_MIN);
    send_operand(0);
  endtask

  // A full fourth-degree polynomial at simple points, one half and one LSB.
  task automatic test_polynomial();
    load_config(Q_ONE, -2 * Q_ONE, Q_ONE / 2, Q_ONE / 4, -Q_ONE / 8, OUT_MIN, OUT_MAX, 0);
    send_operand(0);
    send_operand(Q_ONE);
    send_operand(-Q_ONE);
    send_operand(Q_ONE / 2);
    send_operand(1);
  endtask

  // Accumulator overflow at both ends and a slope term beyond 32 bits.
  task automatic test_saturation();
    load_config(0, 0, 0, 0, OUT_MAX, OUT_MIN, OUT_MAX, 0);
    send_operand(Q_ONE);
    send_operand(OUT_MAX);
    send_operand(OUT_MIN);
    load_config(OUT_MIN, OUT_MAX, 0, 0, 0, OUT_MIN, OUT_MAX, 0);
    send_operand(OUT_MAX);
  endtask

  // Absolute mode: a negative value folds with its slope, a positive one passes,
  // and folding the most negative accumulator saturates. The high bits of the
  // abs_mode writes are set every time and must not matter.
  task automatic test_abs_mode();
    load_config(-3 * Q_ONE, Q_ONE, 0, 0, 0, OUT_MIN, OUT_MAX, 32'hFFFF_FFFF);
    send_operand(0);
    send_operand(5 * Q_ONE);
    load_config(0, 0, 0, 0, OUT_MIN, OUT_MIN, OUT_MAX, 32'hFFFF_FFFF);
    send_operand(OUT_MAX);
    load_config(0, 0, 0, 0, OUT_MIN, OUT_MIN, OUT_MAX, 32'hFFFF_FFFE);
    send_operand(OUT_MAX);
  endtask

  // Clamping with ordinary limits, then with inverted limits where the upper
  // test wins for any value above max_limit.
  task automatic test_clamp();
    load_config(0, Q_ONE, 0, 0, 0, -Q_ONE, Q_ONE, 0);
    send_operand(2 * Q_ONE);
    send_operand(-3 * Q_ONE);
    send_operand(Q_ONE / 2);
    load_config(0, Q_ONE, 0, 0, 0, 2 * Q_ONE, -2 * Q_ONE, 0);
    send_operand(0);
    send_operand(-5 * Q_ONE);
  endtask

  task automatic run_random_items(input int gap_pct, input int stall);
    send_gap_pct = gap_pct;
    stall_pct    = stall;
    for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
      randomize_config();
      for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
        send_operand(random_operand());
      end
    end
  endtask

  // Rare sender gaps with a receiver that stalls more often than not.
  task automatic test_random_receiver_stalls();
    run_random_items(7, 55);
  endtask

  // Long sender gaps with a receiver that rarely stalls.
  task automatic test_random_sender_gaps();
    run_random_items(55, 7);
  endtask

  // Both sides at full rate, one beat every cycle between configuration loads.
  task automatic test_random_full_rate();
    run_random_items(0, 0);
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    x_in      = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_COEF0;
    cfg_data  = '0;
    for (int i = 0; i < NCOEF; i++) begin
      poly_coef[i] = 0;
    end
    lo_clamp = OUT_LO;
    hi_clamp = OUT_HI;
    abs_on   = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // The directed part runs under the first idling pattern.
    send_gap_pct = 7;
    stall_pct    = 55;
    test_reset_state();
    test_polynomial();
    test_saturation();
    test_abs_mode();
    test_clamp();

    test_random_receiver_stalls();
    test_random_sender_gaps();
    test_random_full_rate();

    drain_pipeline();
    if (error_count == 0) begin
      $display("clamped_polynomial_with_slope_test: done, clean");
    end else begin
      $display("clamped_polynomial_with_slope_test: done, errors");
    end
    $finish;
  end

endmodule
